// ===== src/wpms_pkg.sv =====
// wpms_pkg: shared widths and constants for the weighted pixel mean stack
// no dependencies
`timescale 1ns / 1ps
package wpms_pkg;
    localparam int IDX_W   = 16;
    localparam int VAL_W   = 24;
    localparam int WGT_W   = 16;
    localparam int ACC_W   = 52;
    localparam int TOT_W   = 28;
    localparam int PROD_W  = VAL_W + WGT_W + 1;
    localparam int QBITS   = 24;
    localparam int LATENCY = 29;

    localparam logic [WGT_W:0]   ONE_Q8  = 17'd256;
    localparam logic [VAL_W-1:0] MEAN_POS_LIM = 24'h7FFFFF;
    localparam logic [VAL_W-1:0] MEAN_NEG_LIM = 24'h800000;
    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};
endpackage

// ===== src/weighted_pixel_mean_stack.sv =====
// weighted_pixel_mean_stack: per-pixel weighted mean over a stack of planes
// a result strobes for each taken last-plane sample after s1 and the divider pipeline
// throughput: one sample per cycle, busy stays low; read-modify-write on the sum rams
// with one-deep forwarding, then a divider with 24 one-bit quotient stages
// reset: control and use_weights (to 1) clear asynchronously; sum rams are not cleared
// depends on wpms_pkg, wpms_ram, wpms_div
`timescale 1ns / 1ps
module weighted_pixel_mean_stack
    import wpms_pkg::*;
#(
    parameter int PIXELS = 65536
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    cfg_we,
    input  logic                    cfg_wdata,
    input  logic [IDX_W-1:0]        pixel_index,
    input  logic signed [VAL_W-1:0] sample_value,
    input  logic [WGT_W-1:0]        sample_weight,
    input  logic                    sample_valid,
    input  logic                    first_plane,
    input  logic                    last_plane,
    output logic                    result_strobe,
    output logic [IDX_W-1:0]        out_pixel_index,
    output logic signed [VAL_W-1:0] mean_value,
    output logic                    mean_valid
);
    localparam int DEPTH = (PIXELS < 65536) ? PIXELS : 65536;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                    use_weights_reg;
    logic                    accept;
    logic                    in_range;
    logic [WGT_W:0]          wgt;
    logic                    s1_vld_reg;
    logic                    s1_first_reg;
    logic                    s1_last_reg;
    logic                    s1_valid_reg;
    logic [IDX_W-1:0]        s1_idx_reg;
    logic signed [PROD_W-1:0] s1_prod_reg;
    logic [WGT_W:0]          s1_wgt_reg;
    logic                    wb_vld_reg;
    logic [AW-1:0]           wb_addr_reg;
    logic [ACC_W-1:0]        wb_acc_reg;
    logic [TOT_W-1:0]        wb_tot_reg;
    logic [ACC_W-1:0]        rd_acc;
    logic [TOT_W-1:0]        rd_tot;
    logic [AW-1:0]           s1_addr;
    logic [ACC_W-1:0]        base_acc;
    logic [TOT_W-1:0]        base_tot;
    logic signed [ACC_W:0]   sum_acc;
    logic [TOT_W:0]          sum_tot;
    logic [ACC_W-1:0]        new_acc;
    logic [TOT_W-1:0]        new_tot;

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign in_range = (32'(pixel_index) < 32'(DEPTH));
    assign wgt      = use_weights_reg ? {1'b0, sample_weight} : ONE_Q8;
    assign s1_addr  = s1_idx_reg[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_weights_reg <= 1'b1;
            s1_vld_reg      <= 1'b0;
            wb_vld_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                use_weights_reg <= cfg_wdata;
            end
            s1_vld_reg <= accept && in_range;
            wb_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_first_reg <= first_plane;
        s1_last_reg  <= last_plane;
        s1_valid_reg <= sample_valid;
        s1_idx_reg   <= pixel_index;
        s1_prod_reg  <= sample_value * $signed(wgt);
        s1_wgt_reg   <= wgt;
        wb_addr_reg  <= s1_addr;
        wb_acc_reg   <= new_acc;
        wb_tot_reg   <= new_tot;
    end

    wpms_ram #(.WIDTH(ACC_W), .DEPTH(DEPTH)) u_acc_ram (
        .clk   (clk),
        .we    (s1_vld_reg),
        .waddr (s1_addr),
        .wdata (new_acc),
        .raddr (pixel_index[AW-1:0]),
        .rdata (rd_acc)
    );

    wpms_ram #(.WIDTH(TOT_W), .DEPTH(DEPTH)) u_tot_ram (
        .clk   (clk),
        .we    (s1_vld_reg),
        .waddr (s1_addr),
        .wdata (new_tot),
        .raddr (pixel_index[AW-1:0]),
        .rdata (rd_tot)
    );

    // read-modify-write with forwarding of the previous word's write
    always_comb
    begin
        if (s1_first_reg)
        begin
            base_acc = '0;
            base_tot = '0;
        end
        else if (wb_vld_reg && (wb_addr_reg == s1_addr))
        begin
            base_acc = wb_acc_reg;
            base_tot = wb_tot_reg;
        end
        else
        begin
            base_acc = rd_acc;
            base_tot = rd_tot;
        end
        sum_acc = $signed({base_acc[ACC_W-1], base_acc}) + (ACC_W+1)'(s1_prod_reg);
        sum_tot = {1'b0, base_tot} + (TOT_W+1)'(s1_wgt_reg);
        if (!s1_valid_reg)
        begin
            new_acc = base_acc;
            new_tot = base_tot;
        end
        else
        begin
            if (sum_acc[ACC_W] != sum_acc[ACC_W-1])
            begin
                new_acc = sum_acc[ACC_W] ? ACC_MIN : ACC_MAX;
            end
            else
            begin
                new_acc = sum_acc[ACC_W-1:0];
            end
            new_tot = sum_tot[TOT_W] ? TOT_MAX : sum_tot[TOT_W-1:0];
        end
    end

    wpms_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (s1_vld_reg && s1_last_reg),
        .in_idx   (s1_idx_reg),
        .in_acc   (new_acc),
        .in_tot   (new_tot),
        .out_vld  (result_strobe),
        .out_idx  (out_pixel_index),
        .out_mean (mean_value),
        .out_ok   (mean_valid)
    );
endmodule

// ===== src/wpms_ram.sv =====
// wpms_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
`timescale 1ns / 1ps
module wpms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== src/wpms_div.sv =====
// wpms_div: pipelined signed by unsigned divider, one quotient bit per stage
// depends on wpms_pkg
`timescale 1ns / 1ps
module wpms_div
    import wpms_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_vld,
    input  logic [IDX_W-1:0]        in_idx,
    input  logic signed [ACC_W-1:0] in_acc,
    input  logic [TOT_W-1:0]        in_tot,
    output logic                    out_vld,
    output logic [IDX_W-1:0]        out_idx,
    output logic [VAL_W-1:0]        out_mean,
    output logic                    out_ok
);
    // input register
    logic                    a_vld_reg;
    logic [IDX_W-1:0]        a_idx_reg;
    logic signed [ACC_W-1:0] a_acc_reg;
    logic [TOT_W-1:0]        a_tot_reg;
    // magnitude stage
    logic                    b_vld_reg;
    logic [IDX_W-1:0]        b_idx_reg;
    logic [ACC_W-1:0]        b_mag_reg;
    logic                    b_neg_reg;
    logic [TOT_W-1:0]        b_tot_reg;
    // bit stages, index 0 is the overflow check stage
    logic                    d_vld_reg  [QBITS+1];
    logic [IDX_W-1:0]        d_idx_reg  [QBITS+1];
    logic                    d_neg_reg  [QBITS+1];
    logic                    d_ovf_reg  [QBITS+1];
    logic                    d_zero_reg [QBITS+1];
    logic [TOT_W-1:0]        d_tot_reg  [QBITS+1];
    logic [TOT_W-1:0]        d_rem_reg  [QBITS+1];
    logic [QBITS-1:0]        d_low_reg  [QBITS+1];
    logic [QBITS-1:0]        d_q_reg    [QBITS+1];
    logic [ACC_W-1:0]        b_mag_next;
    logic [QBITS-1:0]        lim;
    logic [QBITS-1:0]        qsat;
    logic [VAL_W-1:0]        mean_next;
    logic                    out_vld_reg;
    logic [IDX_W-1:0]        out_idx_reg;
    logic [VAL_W-1:0]        out_mean_reg;
    logic                    out_ok_reg;

    assign b_mag_next = a_acc_reg[ACC_W-1] ? (~a_acc_reg + 1'b1) : a_acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            d_vld_reg[0] <= 1'b0;
        end
        else
        begin
            a_vld_reg <= in_vld;
            b_vld_reg <= a_vld_reg;
            d_vld_reg[0] <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_idx_reg <= in_idx;
        a_acc_reg <= in_acc;
        a_tot_reg <= in_tot;
        b_idx_reg <= a_idx_reg;
        b_mag_reg <= b_mag_next;
        b_neg_reg <= a_acc_reg[ACC_W-1];
        b_tot_reg <= a_tot_reg;
        d_idx_reg[0]  <= b_idx_reg;
        d_neg_reg[0]  <= b_neg_reg;
        d_ovf_reg[0]  <= (b_mag_reg[ACC_W-1:QBITS] >= b_tot_reg);
        d_zero_reg[0] <= (b_tot_reg == '0);
        d_tot_reg[0]  <= b_tot_reg;
        d_rem_reg[0]  <= b_mag_reg[ACC_W-1:QBITS];
        d_low_reg[0]  <= b_mag_reg[QBITS-1:0];
        d_q_reg[0]    <= '0;
    end

    for (genvar k = 1; k <= QBITS; k++)
    begin : g_bit
        logic [TOT_W:0] trial;
        logic           ge;
        logic [TOT_W:0] diff;
        assign trial = {d_rem_reg[k-1], d_low_reg[k-1][QBITS-1]};
        assign diff  = trial - {1'b0, d_tot_reg[k-1]};
        assign ge    = (trial >= {1'b0, d_tot_reg[k-1]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                d_vld_reg[k] <= 1'b0;
            end
            else
            begin
                d_vld_reg[k] <= d_vld_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            d_idx_reg[k]  <= d_idx_reg[k-1];
            d_neg_reg[k]  <= d_neg_reg[k-1];
            d_ovf_reg[k]  <= d_ovf_reg[k-1];
            d_zero_reg[k] <= d_zero_reg[k-1];
            d_tot_reg[k]  <= d_tot_reg[k-1];
            d_rem_reg[k]  <= ge ? diff[TOT_W-1:0] : trial[TOT_W-1:0];
            d_low_reg[k]  <= {d_low_reg[k-1][QBITS-2:0], 1'b0};
            d_q_reg[k]    <= {d_q_reg[k-1][QBITS-2:0], ge};
        end
    end

    // clamp to the signed result range, negate if negative, zero for a zero total
    always_comb
    begin
        lim = d_neg_reg[QBITS] ? MEAN_NEG_LIM : MEAN_POS_LIM;
        if (d_ovf_reg[QBITS] || (d_q_reg[QBITS] > lim))
        begin
            qsat = lim;
        end
        else
        begin
            qsat = d_q_reg[QBITS];
        end
        if (d_zero_reg[QBITS])
        begin
            mean_next = '0;
        end
        else
        begin
            mean_next = d_neg_reg[QBITS] ? (~qsat + 1'b1) : qsat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= d_vld_reg[QBITS];
        end
    end

    always_ff @(posedge clk)
    begin
        out_idx_reg  <= d_idx_reg[QBITS];
        out_mean_reg <= mean_next;
        out_ok_reg   <= !d_zero_reg[QBITS];
    end

    assign out_vld  = out_vld_reg;
    assign out_idx  = out_idx_reg;
    assign out_mean = out_mean_reg;
    assign out_ok   = out_ok_reg;
endmodule

// ===== src/wpms_checker.sv =====
// wpms_checker: port-level checks for weighted_pixel_mean_stack
// depends on wpms_pkg; bound to the top level
`timescale 1ns / 1ps
module wpms_checker
    import wpms_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              last_plane,
    input logic [IDX_W-1:0]  pixel_index,
    input logic              result_strobe,
    input logic [IDX_W-1:0]  out_pixel_index,
    input logic [VAL_W-1:0]  mean_value,
    input logic              mean_valid
);
    a_strobe_cause: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(start && !busy && last_plane, LATENCY))
        else $error("result without a last-plane word");

    a_index_follows: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> (out_pixel_index == $past(pixel_index, LATENCY)))
        else $error("result index does not match its word");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !mean_valid) |-> (mean_value == '0))
        else $error("invalid mean carries a value");
endmodule

bind weighted_pixel_mean_stack wpms_checker u_wpms_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .last_plane      (last_plane),
    .pixel_index     (pixel_index),
    .result_strobe   (result_strobe),
    .out_pixel_index (out_pixel_index),
    .mean_value      (mean_value),
    .mean_valid      (mean_valid)
);

// ===== dv/weighted_pixel_mean_stack_checker.sv =====
// weighted_pixel_mean_stack_checker: predicts and checks the per-pixel weighted means
// watches the sample, configuration and result ports; depends on wpms_pkg
`timescale 1ns / 1ps
module weighted_pixel_mean_stack_checker
    import wpms_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    busy,
    input  logic                    cfg_we,
    input  logic                    cfg_wdata,
    input  logic [IDX_W-1:0]        pixel_index,
    input  logic signed [VAL_W-1:0] sample_value,
    input  logic [WGT_W-1:0]        sample_weight,
    input  logic                    sample_valid,
    input  logic                    first_plane,
    input  logic                    last_plane,
    input  logic                    result_strobe,
    input  logic [IDX_W-1:0]        out_pixel_index,
    input  logic signed [VAL_W-1:0] mean_value,
    input  logic                    mean_valid,
    output int                      fail_count,
    output int                      pending
);
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] mean;
        logic             valid;
    } mean_word_t;

    localparam longint SUM_HI  = (longint'(1) <<< (ACC_W - 1)) - 1;
    localparam longint SUM_LO  = -SUM_HI - 1;
    localparam longint MEAN_HI = 64'sd8388607;
    localparam longint MEAN_LO = -64'sd8388608;

    longint      weighted_sum_mem [int];
    int unsigned weight_sum_mem [int];
    mean_word_t  mean_queue [$];
    logic        use_w;

    task automatic predict_mean();
        longint      acc;
        longint      q;
        int unsigned tot;
        int unsigned w;
        mean_word_t  m;
        w = use_w ? int'(sample_weight) : int'(ONE_Q8);
        if (first_plane || !weighted_sum_mem.exists(int'(pixel_index)))
        begin
            acc = 0;
            tot = 0;
        end
        else
        begin
            acc = weighted_sum_mem[int'(pixel_index)];
            tot = weight_sum_mem[int'(pixel_index)];
        end
        if (sample_valid)
        begin
            acc = acc + longint'(sample_value) * longint'(w);
            if (acc > SUM_HI)
                acc = SUM_HI;
            if (acc < SUM_LO)
                acc = SUM_LO;
            tot = tot + w;
            if (tot > int'(TOT_MAX))
                tot = int'(TOT_MAX);
        end
        weighted_sum_mem[int'(pixel_index)] = acc;
        weight_sum_mem[int'(pixel_index)] = tot;
        if (last_plane)
        begin
            m.idx = pixel_index;
            if (tot == 0)
            begin
                m.mean = '0;
                m.valid = 1'b0;
            end
            else
            begin
                q = acc / longint'(tot);
                if (q > MEAN_HI)
                    q = MEAN_HI;
                if (q < MEAN_LO)
                    q = MEAN_LO;
                m.mean = q[VAL_W-1:0];
                m.valid = 1'b1;
            end
            mean_queue = {mean_queue, m};
        end
    endtask

    task automatic note_fail(input mean_word_t exp_w, input mean_word_t got_w);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch: expected idx %0d mean %0d valid %0b, %s",
                exp_w.idx, $signed(exp_w.mean), exp_w.valid,
                $sformatf("got idx %0d mean %0d valid %0b",
                    got_w.idx, $signed(got_w.mean), got_w.valid));
    endtask

    initial
    begin
        fail_count = 0;
        use_w = 1'b1;
    end

    assign pending = mean_queue.size();

    always @(posedge clk)
    begin
        mean_word_t got_w;
        mean_word_t exp_w;
        if (!rst_n)
        begin
            use_w <= 1'b1;
        end
        else
        begin
            if (cfg_we)
                use_w <= cfg_wdata;
            if (start && !busy)
                predict_mean();
            if (result_strobe)
            begin
                got_w.idx = out_pixel_index;
                got_w.mean = mean_value;
                got_w.valid = mean_valid;
                if (mean_queue.size() == 0)
                begin
                    exp_w = '0;
                    note_fail(exp_w, got_w);
                end
                else
                begin
                    exp_w = mean_queue.pop_front();
                    if (exp_w.idx !== got_w.idx || exp_w.mean !== got_w.mean
                        || exp_w.valid !== got_w.valid)
                        note_fail(exp_w, got_w);
                end
            end
        end
    end
endmodule

// ===== dv/tb_weighted_pixel_mean_stack.sv =====
// tb_weighted_pixel_mean_stack: stimulus and verdict for the weighted pixel mean stack
// drives directed, stacked and saturating sample words; depends on wpms_pkg and the checker
`timescale 1ns / 1ps
module tb_weighted_pixel_mean_stack;
    import wpms_pkg::*;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic                    cfg_we;
    logic                    cfg_wdata;
    logic [IDX_W-1:0]        pixel_index;
    logic signed [VAL_W-1:0] sample_value;
    logic [WGT_W-1:0]        sample_weight;
    logic                    sample_valid;
    logic                    first_plane;
    logic                    last_plane;
    logic                    result_strobe;
    logic [IDX_W-1:0]        out_pixel_index;
    logic signed [VAL_W-1:0] mean_value;
    logic                    mean_valid;
    int                      fail_count;
    int                      pending;

    bit started [65536];
    int word_count;
    bit allow_gaps;

    weighted_pixel_mean_stack i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .pixel_index(pixel_index), .sample_value(sample_value),
        .sample_weight(sample_weight), .sample_valid(sample_valid),
        .first_plane(first_plane), .last_plane(last_plane),
        .result_strobe(result_strobe), .out_pixel_index(out_pixel_index),
        .mean_value(mean_value), .mean_valid(mean_valid)
    );

    weighted_pixel_mean_stack_checker i_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .pixel_index(pixel_index), .sample_value(sample_value),
        .sample_weight(sample_weight), .sample_valid(sample_valid),
        .first_plane(first_plane), .last_plane(last_plane),
        .result_strobe(result_strobe), .out_pixel_index(out_pixel_index),
        .mean_value(mean_value), .mean_valid(mean_valid),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    task automatic idle_cycles(input int n);
        @(negedge clk);
        start <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic send_word(input int idx, input int val, input int wgt,
                             input bit vld, input bit fst, input bit lst);
        if (allow_gaps && $urandom_range(0, 7) == 0)
            idle_cycles($urandom_range(1, 8));
        if (!started[idx])
            fst = 1'b1;
        started[idx] = 1'b1;
        @(negedge clk);
        start <= 1'b1;
        pixel_index <= idx[IDX_W-1:0];
        sample_value <= val[VAL_W-1:0];
        sample_weight <= wgt[WGT_W-1:0];
        sample_valid <= vld;
        first_plane <= fst;
        last_plane <= lst;
        do
            @(posedge clk);
        while (busy);
        word_count++;
    endtask

    // drain everything, let trailing non-result words settle, then write the register
    task automatic drain_and_write(input bit wdata);
        idle_cycles(1);
        while (pending != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= wdata;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_weight(output int wgt);
        case ($urandom_range(0, 5))
            0: wgt = 0;
            1: wgt = 65535;
            2: wgt = $urandom_range(0, 3);
            default: wgt = $urandom_range(0, 65535);
        endcase
    endtask

    task automatic random_stacks(input int n_words);
        int target;
        int base;
        int npix;
        int nplanes;
        int wgt;
        int idx;
        target = word_count + n_words;
        while (word_count < target)
        begin
            if ($urandom_range(0, 4) != 0)
            begin
                base = $urandom_range(0, 65535);
                npix = $urandom_range(1, 6);
                nplanes = $urandom_range(1, 5);
                for (int p = 0; p < nplanes; p++)
                    for (int k = 0; k < npix; k++)
                    begin
                        random_weight(wgt);
                        send_word((base + k) % 65536, $urandom, wgt,
                            $urandom_range(0, 9) != 0, p == 0, p == nplanes - 1);
                    end
            end
            else
            begin
                if ($urandom_range(0, 1))
                    idx = $urandom_range(0, 3);
                else
                    idx = $urandom_range(0, 65535);
                random_weight(wgt);
                send_word(idx, $urandom, wgt, $urandom_range(0, 1),
                    $urandom_range(0, 3) == 0, $urandom_range(0, 1));
            end
        end
    endtask

    task automatic saturating_stack(input int idx, input int val);
        for (int p = 0; p < 200; p++)
            send_word(idx, val, 65535, 1'b1, p == 0, (p % 50) == 49);
    endtask

    initial
    begin
        #(12 * 2000000);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        pixel_index = '0;
        sample_value = '0;
        sample_weight = '0;
        sample_valid = 1'b0;
        first_plane = 1'b0;
        last_plane = 1'b0;
        word_count = 0;
        allow_gaps = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // directed words
        send_word(0, 8388607, 65535, 1, 1, 1);
        send_word(1, -8388608, 65535, 1, 1, 1);
        send_word(2, 1234, 500, 0, 1, 1);
        send_word(3, 777, 0, 1, 1, 1);
        send_word(65535, -5, 256, 1, 1, 0);
        send_word(65535, 100, 9, 0, 0, 0);
        send_word(65535, 2, 1, 1, 0, 1);
        send_word(4, -7, 1, 1, 1, 0);
        send_word(4, 0, 2, 1, 0, 0);
        send_word(4, -1, 65535, 1, 0, 1);
        send_word(5, 3, 100, 1, 1, 0);
        send_word(5, 4, 200, 1, 0, 1);
        send_word(5, -9, 3, 1, 0, 1);
        send_word(6, 0, 0, 0, 1, 0);
        send_word(6, 0, 0, 0, 0, 1);
        drain_and_write(1'b0);
        send_word(7, -8388608, 0, 1, 1, 0);
        send_word(7, 8388607, 65535, 1, 0, 1);
        send_word(8, 11, 5, 0, 1, 1);

        allow_gaps = 1'b1;
        random_stacks(400);
        drain_and_write(1'b1);
        random_stacks(400);
        drain_and_write(1'b0);
        saturating_stack(9, 8388607);
        drain_and_write(1'b1);
        saturating_stack(10, 8388607);
        saturating_stack(11, -8388608);
        random_stacks(300);
        allow_gaps = 1'b0;
        random_stacks(300);

        idle_cycles(1);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
